// ===== rtl/olst_pkg.sv =====
package olst_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CNT_W     = 11;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_APPEND     = 3'd1;
    localparam logic [2:0] MODE_REMOVE     = 3'd2;
    localparam logic [2:0] MODE_SEARCH     = 3'd3;
    localparam logic [2:0] MODE_COUNT      = 3'd4;
    localparam logic [2:0] MODE_LIST       = 3'd5;

    localparam logic [3:0] STAT_INSERTED = 4'd0;
    localparam logic [3:0] STAT_FULL     = 4'd1;
    localparam logic [3:0] STAT_DELETED  = 4'd2;
    localparam logic [3:0] STAT_BADPOS   = 4'd3;
    localparam logic [3:0] STAT_FOUND    = 4'd4;
    localparam logic [3:0] STAT_NOTFOUND = 4'd5;
    localparam logic [3:0] STAT_COUNT    = 4'd6;
    localparam logic [3:0] STAT_ENTRY    = 4'd7;
    localparam logic [3:0] STAT_EMPTY    = 4'd8;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         status;
        logic signed [31:0] element;
        logic [6:0]         entries;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_APPEND,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   pos;
    } t_cell_cmd;

endpackage

// ===== rtl/olst_cell.sv =====
module olst_cell import olst_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_cmd          i_cmd,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_value
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            OP_HOLD:    n_value = r_value;
            OP_PUSH:    n_value = (IDX_C == '0) ? i_cmd.value : i_left;
            OP_APPEND:  n_value = (IDX_C == i_cmd.count) ? i_cmd.value : r_value;
            OP_REMOVE:  n_value = (IDX_C >= i_cmd.pos) ? i_right : r_value;
            OP_ROTATE:  n_value = i_right;
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/ordered_list_store.sv =====
// Insert, delete and count: one item per cycle unless the output stalls; result registered on
// acceptance. Search and list: the ring of DEPTH cells rotates once round, one step a cycle
// unless the output stalls an emitted entry or search result, and holds the input meanwhile.
// List registers its first entry at step 0, then one entry per cycle unless stalled.
// Reset (synchronous, active low) clears the count and control; cell contents are undefined.
module ordered_list_store import olst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (CW > 8) ? CW : 8;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ROT  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_step, n_step;
    logic               r_list, n_list;
    logic               r_hit, n_hit;
    logic signed [31:0] r_key, n_key;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_cell_cmd          w_cmd;
    logic signed [31:0] w_cell [DEPTH];
    logic               out_free, in_acc, in_range, last_step, emit, advance, match;
    logic               load;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            olst_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_left  (w_cell[(g + DEPTH - 1) % DEPTH]),
                .i_right (w_cell[(g + 1) % DEPTH]),
                .o_value (w_cell[g])
            );
        end
    endgenerate

    assign out_free  = !r_out_valid || i_ready;
    assign o_ready   = (r_state == ST_IDLE) && out_free;
    assign in_acc    = i_valid && o_ready;
    assign in_range  = CW'(r_step) < r_count;
    assign last_step = r_step == SW'(DEPTH - 1);
    assign match     = in_range && (w_cell[0] == r_key);
    assign emit      = r_list ? in_range : last_step;
    assign advance   = !emit || out_free;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_list   = r_list;
        n_hit    = r_hit;
        n_key    = r_key;
        load     = 1'b0;
        n_out    = r_out;
        w_cmd.op    = OP_HOLD;
        w_cmd.value = i_item.value;
        w_cmd.count = CNT_W'(r_count);
        w_cmd.pos   = CNT_W'(i_item.position);

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_out.element = '0;
                    n_out.last    = 1'b1;
                    n_out.status  = STAT_COUNT;
                    case (i_item.mode) inside
                        MODE_PUSH_FRONT, MODE_APPEND: begin
                            load = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                w_cmd.op     = (i_item.mode == MODE_PUSH_FRONT) ? OP_PUSH
                                                                                : OP_APPEND;
                                n_count      = r_count + 1'b1;
                                n_out.status = STAT_INSERTED;
                            end
                        end
                        MODE_REMOVE: begin
                            load = 1'b1;
                            if (PW'(i_item.position) >= PW'(r_count)) begin
                                n_out.status = STAT_BADPOS;
                            end else begin
                                w_cmd.op     = OP_REMOVE;
                                n_count      = r_count - 1'b1;
                                n_out.status = STAT_DELETED;
                            end
                        end
                        MODE_SEARCH: begin
                            n_state = ST_ROT;
                            n_list  = 1'b0;
                            n_hit   = 1'b0;
                            n_key   = i_item.value;
                            n_step  = '0;
                        end
                        MODE_COUNT: begin
                            load = 1'b1;
                        end
                        MODE_LIST: begin
                            if (r_count == '0) begin
                                load         = 1'b1;
                                n_out.status = STAT_EMPTY;
                            end else begin
                                n_state = ST_ROT;
                                n_list  = 1'b1;
                                n_step  = '0;
                            end
                        end
                        default: ;
                    endcase
                    n_out.entries = 7'(n_count);
                end
            end
            ST_ROT: begin
                if (advance) begin
                    w_cmd.op = OP_ROTATE;
                    n_step   = r_step + 1'b1;
                    n_hit    = r_hit || match;
                    if (last_step) begin
                        n_state = ST_IDLE;
                    end
                    if (emit) begin
                        load          = 1'b1;
                        n_out.entries = 7'(r_count);
                        if (r_list) begin
                            n_out.status  = STAT_ENTRY;
                            n_out.element = w_cell[0];
                            n_out.last    = (CW'(r_step) + 1'b1) == r_count;
                        end else begin
                            n_out.status  = (r_hit || match) ? STAT_FOUND : STAT_NOTFOUND;
                            n_out.element = '0;
                            n_out.last    = 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_list      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_list      <= n_list;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_item.mode == MODE_PUSH_FRONT || i_item.mode == MODE_APPEND)
         && r_count == CW'(DEPTH)) |=> $stable(r_count))
        else $error("insert into full list changed count");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> !o_ready)
        else $error("input accepted during rotation");

    a_list_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.mode == MODE_LIST && r_count != '0) |=> (r_state == ST_ROT))
        else $error("list of non-empty store did not rotate");

    a_rot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |=> (r_count == $past(r_count)))
        else $error("count changed during rotation");

endmodule
